### design/frame_peak_limiter_assert.svh
// Assertion macros for the frame peak limiter.
`ifndef FRAME_PEAK_LIMITER_ASSERT_SVH
`define FRAME_PEAK_LIMITER_ASSERT_SVH

// Property checked on every clock edge outside reset.
`define FPL_ASSERT(lbl, clk, rst_n, prop) \
  lbl: assert property (@(posedge clk) disable iff (!rst_n) (prop)) \
    else $error("fpl assertion failed");

// Same-cycle implication.
`define FPL_ASSERT_IMP(lbl, clk, rst_n, ante, cons) \
  lbl: assert property (@(posedge clk) disable iff (!rst_n) (ante) |-> (cons)) \
    else $error("fpl assertion failed");

// Next-cycle implication.
`define FPL_ASSERT_NXT(lbl, clk, rst_n, ante, cons) \
  lbl: assert property (@(posedge clk) disable iff (!rst_n) (ante) |=> (cons)) \
    else $error("fpl assertion failed");

`endif

### design/fpl_pkg.sv
// Shared types and constants of the frame peak limiter.
package fpl_pkg;

  localparam int unsigned SAMPLE_W      = 16;
  localparam int unsigned PEAK_W        = 16;
  localparam int unsigned LIMIT_W       = 15;
  localparam int unsigned PROD_W        = 30;
  localparam int unsigned QUO_W         = 15;
  localparam int unsigned CFG_IDX_W     = 1;
  localparam int unsigned FRAME_MAX_DEF = 2048;
  localparam logic [LIMIT_W-1:0] LIMIT_RST = 15'd6000;

  typedef enum logic [CFG_IDX_W-1:0] {
    CFG_ENABLE = 1'b0,
    CFG_LIMIT  = 1'b1
  } fpl_cfg_e;

  typedef enum logic {
    OP_LOAD  = 1'b0,
    OP_DRAIN = 1'b1
  } fpl_op_e;

  typedef enum logic {
    KIND_SAMPLE  = 1'b0,
    KIND_SUMMARY = 1'b1
  } fpl_kind_e;

  typedef struct packed {
    logic busy;
    logic done;
  } fpl_div_stat_t;

endpackage

### design/frame_peak_limiter.sv
// Frame peak limiter: frame buffer, peak tracking and serial scaling.
//
// Channels: an input channel (in_valid_i/in_ready_o) carries load and drain
// beats; an output channel (out_valid_o/out_ready_i) returns drained samples
// and one summary beat per closed frame; a config channel writes the enable
// and limit registers (always ready).
// A load beat without frame_end leaves the block idle; one marked frame_end
// stages its summary in the done state. A drain beat reads the frame
// buffer into a register. A pass-through sample goes from the read state
// to the done state. A scaled sample is multiplied by the latched limit in
// the read state, then passes the multiply state and the serial divider
// (15 quotient bits, then a done flag) before the done state. The block
// takes no new beat while a drain or summary is in work.
// A finished result sits in the output register; the next beat is taken
// while it waits. If the receiver stalls and another result is ready, the
// block holds in its final state until the output register frees.
// Reset clears counters, flags and config (enable 1, limit 6000); buffer
// contents are not cleared and are only read after being written.
module frame_peak_limiter #(
  parameter int unsigned FRAME_MAX = fpl_pkg::FRAME_MAX_DEF
) (
  input  logic                             clk_i,
  input  logic                             rst_ni,
  input  logic                             in_valid_i,
  output logic                             in_ready_o,
  input  logic                             opcode_i,
  input  logic signed [fpl_pkg::SAMPLE_W-1:0] sample_in_i,
  input  logic                             frame_end_i,
  output logic                             out_valid_o,
  input  logic                             out_ready_i,
  output logic                             result_kind_o,
  output logic signed [fpl_pkg::SAMPLE_W-1:0] sample_out_o,
  output logic                             last_out_o,
  output logic [fpl_pkg::PEAK_W-1:0]       peak_level_o,
  output logic                             over_limit_o,
  output logic                             frame_overflow_o,
  input  logic                             cfg_valid_i,
  output logic                             cfg_ready_o,
  input  logic [fpl_pkg::CFG_IDX_W-1:0]    cfg_index_i,
  input  logic [fpl_pkg::LIMIT_W-1:0]      cfg_data_i
);
  import fpl_pkg::*;

  `include "frame_peak_limiter_assert.svh"

  localparam int unsigned CW = $clog2(FRAME_MAX + 1);
  localparam int unsigned AW = $clog2(FRAME_MAX);

  typedef enum logic [4:0] {
    S_IDLE = 5'b00001,
    S_READ = 5'b00010,
    S_MUL  = 5'b00100,
    S_DIV  = 5'b01000,
    S_DONE = 5'b10000
  } state_e;

  state_e state_q, state_d;

  logic [SAMPLE_W-1:0] mem [FRAME_MAX];
  logic [SAMPLE_W-1:0] rdata_q;
  logic                mem_we;
  logic [AW-1:0]       mem_waddr;

  logic [CW-1:0]      cnt_q, cnt_d;
  logic [CW-1:0]      drain_q, drain_d;
  logic [PEAK_W-1:0]  peak_q, peak_d;
  logic               scale_q, scale_d;
  logic               ovf_q, ovf_d;
  logic               closed_q, closed_d;
  logic [LIMIT_W-1:0] latched_q, latched_d;
  logic               en_q;
  logic [LIMIT_W-1:0] limit_q;

  logic               res_kind_q, res_kind_d;
  logic [SAMPLE_W-1:0] res_sample_q, res_sample_d;
  logic               res_last_q, res_last_d;
  logic [PEAK_W-1:0]  res_peak_q, res_peak_d;
  logic               res_over_q, res_over_d;
  logic               res_ovf_q, res_ovf_d;

  logic               out_valid_q, out_valid_d;
  logic               out_kind_q;
  logic [SAMPLE_W-1:0] out_sample_q;
  logic               out_last_q;
  logic [PEAK_W-1:0]  out_peak_q;
  logic               out_over_q;
  logic               out_ovf_q;
  logic               out_load;

  logic               sign_q, sign_d;
  logic [PROD_W-1:0]  prod_q, prod_d;
  logic [PEAK_W-1:0]  rd_mag;
  logic [PEAK_W-1:0]  in_mag;
  logic [CW-1:0]      base_cnt;
  logic [PEAK_W-1:0]  base_peak;
  logic [QUO_W-1:0]   quotient;
  fpl_div_stat_t      div_stat;
  logic               accept;

  assign accept     = in_valid_i && in_ready_o;
  assign in_ready_o = (state_q == S_IDLE);
  assign out_load   = (state_q == S_DONE) && (!out_valid_q || out_ready_i);

  assign in_mag    = sample_in_i[SAMPLE_W-1] ? PEAK_W'(-sample_in_i) : PEAK_W'(sample_in_i);
  assign rd_mag    = rdata_q[SAMPLE_W-1] ? PEAK_W'(-rdata_q) : rdata_q;
  assign base_cnt  = closed_q ? '0 : cnt_q;
  assign base_peak = closed_q ? '0 : peak_q;
  assign mem_waddr = base_cnt[AW-1:0];

  always_comb begin
    state_d      = state_q;
    cnt_d        = cnt_q;
    drain_d      = drain_q;
    peak_d       = peak_q;
    scale_d      = scale_q;
    ovf_d        = ovf_q;
    closed_d     = closed_q;
    latched_d    = latched_q;
    res_kind_d   = res_kind_q;
    res_sample_d = res_sample_q;
    res_last_d   = res_last_q;
    res_peak_d   = res_peak_q;
    res_over_d   = res_over_q;
    res_ovf_d    = res_ovf_q;
    sign_d       = sign_q;
    prod_d       = prod_q;
    mem_we       = 1'b0;
    unique case (state_q)
      S_IDLE: begin
        if (accept) begin
          if (opcode_i == OP_LOAD) begin
            closed_d = 1'b0;
            scale_d  = 1'b0;
            drain_d  = '0;
            ovf_d    = closed_q ? 1'b0 : ovf_q;
            if (base_cnt < CW'(FRAME_MAX)) begin
              mem_we = 1'b1;
              cnt_d  = base_cnt + CW'(1);
            end else begin
              cnt_d = base_cnt;
              ovf_d = 1'b1;
            end
            peak_d = (in_mag > base_peak) ? in_mag : base_peak;
            if (frame_end_i) begin
              closed_d     = 1'b1;
              latched_d    = limit_q;
              scale_d      = en_q && (peak_d > PEAK_W'(limit_q));
              res_kind_d   = KIND_SUMMARY;
              res_sample_d = '0;
              res_last_d   = 1'b0;
              res_peak_d   = peak_d;
              res_over_d   = scale_d;
              res_ovf_d    = ovf_d;
              state_d      = S_DONE;
            end
          end else if (closed_q && (drain_q < cnt_q)) begin
            res_kind_d = KIND_SAMPLE;
            res_last_d = (CW'(drain_q + CW'(1)) == cnt_q);
            res_peak_d = '0;
            res_over_d = 1'b0;
            res_ovf_d  = 1'b0;
            drain_d    = drain_q + CW'(1);
            state_d    = S_READ;
          end
        end
      end
      S_READ: begin
        sign_d       = rdata_q[SAMPLE_W-1];
        prod_d       = PROD_W'(rd_mag) * PROD_W'(latched_q);
        res_sample_d = rdata_q;
        state_d      = scale_q ? S_MUL : S_DONE;
      end
      S_MUL: begin
        state_d = S_DIV;
      end
      S_DIV: begin
        if (div_stat.done) begin
          res_sample_d = sign_q ? SAMPLE_W'(-{1'b0, quotient}) : SAMPLE_W'({1'b0, quotient});
          state_d      = S_DONE;
        end
      end
      S_DONE: begin
        if (out_load) begin
          state_d = S_IDLE;
        end
      end
      default: begin
        state_d = S_IDLE;
      end
    endcase
  end

  always_comb begin
    out_valid_d = out_valid_q;
    if (out_valid_q && out_ready_i) begin
      out_valid_d = 1'b0;
    end
    if (out_load) begin
      out_valid_d = 1'b1;
    end
  end

  fpl_divider u_div (
    .clk_i      (clk_i),
    .rst_ni     (rst_ni),
    .start_i    (state_q == S_MUL),
    .dividend_i (prod_q),
    .divisor_i  (peak_q),
    .quotient_o (quotient),
    .stat_o     (div_stat)
  );

  always_ff @(posedge clk_i) begin
    if (mem_we) begin
      mem[mem_waddr] <= sample_in_i;
    end
    rdata_q <= mem[drain_q[AW-1:0]];
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      state_q     <= S_IDLE;
      cnt_q       <= '0;
      drain_q     <= '0;
      peak_q      <= '0;
      scale_q     <= 1'b0;
      ovf_q       <= 1'b0;
      closed_q    <= 1'b0;
      latched_q   <= '0;
      en_q        <= 1'b1;
      limit_q     <= LIMIT_RST;
      out_valid_q <= 1'b0;
    end else begin
      state_q     <= state_d;
      cnt_q       <= cnt_d;
      drain_q     <= drain_d;
      peak_q      <= peak_d;
      scale_q     <= scale_d;
      ovf_q       <= ovf_d;
      closed_q    <= closed_d;
      latched_q   <= latched_d;
      out_valid_q <= out_valid_d;
      if (cfg_valid_i && cfg_ready_o) begin
        unique case (cfg_index_i)
          CFG_ENABLE: en_q    <= cfg_data_i[0];
          CFG_LIMIT:  limit_q <= cfg_data_i;
          default:    limit_q <= limit_q;
        endcase
      end
    end
  end

  always_ff @(posedge clk_i) begin
    res_kind_q   <= res_kind_d;
    res_sample_q <= res_sample_d;
    res_last_q   <= res_last_d;
    res_peak_q   <= res_peak_d;
    res_over_q   <= res_over_d;
    res_ovf_q    <= res_ovf_d;
    sign_q       <= sign_d;
    prod_q       <= prod_d;
    if (out_load) begin
      out_kind_q   <= res_kind_q;
      out_sample_q <= res_sample_q;
      out_last_q   <= res_last_q;
      out_peak_q   <= res_peak_q;
      out_over_q   <= res_over_q;
      out_ovf_q    <= res_ovf_q;
    end
  end

  assign cfg_ready_o      = 1'b1;
  assign out_valid_o      = out_valid_q;
  assign result_kind_o    = out_kind_q;
  assign sample_out_o     = out_sample_q;
  assign last_out_o       = out_last_q;
  assign peak_level_o     = out_peak_q;
  assign over_limit_o     = out_over_q;
  assign frame_overflow_o = out_ovf_q;

  `FPL_ASSERT(a_cnt_bound, clk_i, rst_ni, cnt_q <= CW'(FRAME_MAX))
  `FPL_ASSERT(a_drain_bound, clk_i, rst_ni, drain_q <= cnt_q)
  `FPL_ASSERT_IMP(a_div_in_div, clk_i, rst_ni, div_stat.busy, state_q == S_DIV)
  `FPL_ASSERT_IMP(a_scale_peak, clk_i, rst_ni, scale_q, peak_q > PEAK_W'(latched_q))
  `FPL_ASSERT_NXT(a_out_loaded, clk_i, rst_ni, out_load, out_valid_q)

endmodule

### design/fpl_divider.sv
// Restoring divider, one quotient bit per cycle.
module fpl_divider (
  input  logic                           clk_i,
  input  logic                           rst_ni,
  input  logic                           start_i,
  input  logic [fpl_pkg::PROD_W-1:0]     dividend_i,
  input  logic [fpl_pkg::PEAK_W-1:0]     divisor_i,
  output logic [fpl_pkg::QUO_W-1:0]      quotient_o,
  output fpl_pkg::fpl_div_stat_t         stat_o
);
  import fpl_pkg::*;

  localparam int unsigned CNT_W = $clog2(QUO_W + 1);

  logic [QUO_W-1:0] rem_q, rem_d;
  logic [QUO_W-1:0] dvd_q, dvd_d;
  logic [CNT_W-1:0] cnt_q, cnt_d;
  logic             busy_q, busy_d;
  logic             done_q, done_d;
  logic [QUO_W:0]   shifted;
  logic [QUO_W+1:0] diff;

  // Quotient is known to fit QUO_W bits, so the top half seeds the remainder.
  always_comb begin
    shifted = {rem_q, dvd_q[QUO_W-1]};
    diff    = {1'b0, shifted} - {1'b0, divisor_i};
    rem_d   = rem_q;
    dvd_d   = dvd_q;
    cnt_d   = cnt_q;
    busy_d  = busy_q;
    done_d  = 1'b0;
    if (start_i) begin
      rem_d  = dividend_i[PROD_W-1:QUO_W];
      dvd_d  = dividend_i[QUO_W-1:0];
      cnt_d  = CNT_W'(QUO_W);
      busy_d = 1'b1;
    end else if (busy_q) begin
      if (diff[QUO_W+1]) begin
        rem_d = shifted[QUO_W-1:0];
        dvd_d = {dvd_q[QUO_W-2:0], 1'b0};
      end else begin
        rem_d = diff[QUO_W-1:0];
        dvd_d = {dvd_q[QUO_W-2:0], 1'b1};
      end
      cnt_d = cnt_q - CNT_W'(1);
      if (cnt_q == CNT_W'(1)) begin
        busy_d = 1'b0;
        done_d = 1'b1;
      end
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      busy_q <= 1'b0;
      done_q <= 1'b0;
      cnt_q  <= '0;
    end else begin
      busy_q <= busy_d;
      done_q <= done_d;
      cnt_q  <= cnt_d;
    end
  end

  always_ff @(posedge clk_i) begin
    rem_q <= rem_d;
    dvd_q <= dvd_d;
  end

  assign quotient_o  = dvd_q;
  assign stat_o.busy = busy_q;
  assign stat_o.done = done_q;

endmodule

### tb/tb.sv
// Self-checking testbench for frame_peak_limiter: directed and random frames against a predictor.
`timescale 1ns / 1ps

module tb;
  import fpl_pkg::*;

  localparam int unsigned FRAME_DEPTH  = FRAME_MAX_DEF;
  localparam int unsigned SETTLE_CYC   = 40;
  localparam int unsigned STALL_LIMIT  = 2000;
  localparam int unsigned RANDOM_BEATS = 1000;

  typedef struct packed {
    fpl_kind_e                 kind;
    logic signed [SAMPLE_W-1:0] smp;
    logic                      last;
    logic [PEAK_W-1:0]         peak;
    logic                      over;
    logic                      ovf;
  } fpl_result_t;

  logic                       clk_i;
  logic                       rst_ni;
  logic                       in_valid_i;
  logic                       in_ready_o;
  logic                       opcode_i;
  logic signed [SAMPLE_W-1:0] sample_in_i;
  logic                       frame_end_i;
  logic                       out_valid_o;
  logic                       out_ready_i;
  logic                       result_kind_o;
  logic signed [SAMPLE_W-1:0] sample_out_o;
  logic                       last_out_o;
  logic [PEAK_W-1:0]          peak_level_o;
  logic                       over_limit_o;
  logic                       frame_overflow_o;
  logic                       cfg_valid_i;
  logic                       cfg_ready_o;
  logic [CFG_IDX_W-1:0]       cfg_index_i;
  logic [LIMIT_W-1:0]         cfg_data_i;

  frame_peak_limiter #(
    .FRAME_MAX(FRAME_DEPTH)
  ) i_dut (
    .clk_i           (clk_i),
    .rst_ni          (rst_ni),
    .in_valid_i      (in_valid_i),
    .in_ready_o      (in_ready_o),
    .opcode_i        (opcode_i),
    .sample_in_i     (sample_in_i),
    .frame_end_i     (frame_end_i),
    .out_valid_o     (out_valid_o),
    .out_ready_i     (out_ready_i),
    .result_kind_o   (result_kind_o),
    .sample_out_o    (sample_out_o),
    .last_out_o      (last_out_o),
    .peak_level_o    (peak_level_o),
    .over_limit_o    (over_limit_o),
    .frame_overflow_o(frame_overflow_o),
    .cfg_valid_i     (cfg_valid_i),
    .cfg_ready_o     (cfg_ready_o),
    .cfg_index_i     (cfg_index_i),
    .cfg_data_i      (cfg_data_i)
  );

  // predictor state
  logic signed [SAMPLE_W-1:0] buf_mem [FRAME_DEPTH];
  int unsigned                buf_fill;
  int unsigned                buf_rd;
  int unsigned                frame_peak;
  bit                         scale_on;
  bit                         ovf_flag;
  bit                         frame_done;
  logic [LIMIT_W-1:0]         limit_held;
  bit                         en_cfg;
  logic [LIMIT_W-1:0]         limit_cfg;

  fpl_result_t pending_results[$];
  int unsigned mismatch_cnt;
  int unsigned stall_cycles;
  bit          steady;

  initial begin
    clk_i = 1'b0;
    forever #10 clk_i = ~clk_i;
  end

  function automatic bit limiter_predict(input fpl_op_e op, input logic signed [SAMPLE_W-1:0] smp,
                                         input logic fe, output fpl_result_t res);
    int                s;
    int                mag;
    int unsigned       quo;
    logic [SAMPLE_W-1:0] q16;
    res = '0;
    if (op == OP_LOAD) begin
      s   = smp;
      mag = (s < 0) ? -s : s;
      if (frame_done) begin
        frame_done = 1'b0;
        buf_fill   = 0;
        buf_rd     = 0;
        frame_peak = 0;
        ovf_flag   = 1'b0;
        scale_on   = 1'b0;
      end
      if (buf_fill < FRAME_DEPTH) begin
        buf_mem[buf_fill] = smp;
        buf_fill++;
      end else begin
        ovf_flag = 1'b1;
      end
      if (mag > frame_peak) frame_peak = mag;
      if (!fe) return 1'b0;
      frame_done = 1'b1;
      buf_rd     = 0;
      limit_held = limit_cfg;
      scale_on   = en_cfg && (frame_peak > limit_cfg);
      res.kind   = KIND_SUMMARY;
      res.peak   = frame_peak[PEAK_W-1:0];
      res.over   = scale_on;
      res.ovf    = ovf_flag;
      return 1'b1;
    end
    if (!frame_done || buf_rd >= buf_fill) return 1'b0;
    s   = buf_mem[buf_rd];
    mag = (s < 0) ? -s : s;
    res.kind = KIND_SAMPLE;
    if (!scale_on || frame_peak == 0) begin
      res.smp = buf_mem[buf_rd];
    end else begin
      quo     = (mag * limit_held) / frame_peak;
      q16     = quo[SAMPLE_W-1:0];
      res.smp = (s < 0) ? -q16 : q16;
    end
    res.last = (buf_rd + 1 == buf_fill);
    buf_rd++;
    return 1'b1;
  endfunction

  task automatic send_beat(input fpl_op_e op, input logic signed [SAMPLE_W-1:0] smp,
                           input logic fe);
    fpl_result_t res;
    while (!steady && $urandom_range(0, 99) < 27) begin
      in_valid_i <= 1'b0;
      @(posedge clk_i);
    end
    in_valid_i  <= 1'b1;
    opcode_i    <= op;
    sample_in_i <= smp;
    frame_end_i <= fe;
    @(posedge clk_i);
    while (!in_ready_o) @(posedge clk_i);
    if (limiter_predict(op, smp, fe, res)) pending_results.push_back(res);
  endtask

  // sender pauses until every expected result is out, then lets the block settle
  task automatic wait_idle();
    in_valid_i <= 1'b0;
    while (pending_results.size() != 0) @(posedge clk_i);
    repeat (SETTLE_CYC) @(posedge clk_i);
  endtask

  task automatic write_reg(input fpl_cfg_e idx, input logic [LIMIT_W-1:0] data);
    cfg_valid_i <= 1'b1;
    cfg_index_i <= idx;
    cfg_data_i  <= data;
    @(posedge clk_i);
    while (!cfg_ready_o) @(posedge clk_i);
    if (idx == CFG_ENABLE) en_cfg = data[0];
    else limit_cfg = data;
    cfg_valid_i <= 1'b0;
    @(posedge clk_i);
  endtask

  function automatic logic signed [SAMPLE_W-1:0] pick_sample();
    case ($urandom_range(0, 7))
      0:       return -16'sd32768;
      1:       return 16'sd32767;
      2:       return SAMPLE_W'($signed($urandom_range(0, 600)) - 300);
      default: return SAMPLE_W'($urandom());
    endcase
  endfunction

  task automatic load_frame(input int unsigned len);
    for (int unsigned k = 0; k < len; k++) send_beat(OP_LOAD, pick_sample(), k == len - 1);
  endtask

  task automatic drain_beats(input int unsigned n);
    repeat (n) send_beat(OP_DRAIN, SAMPLE_W'($urandom()), 1'($urandom_range(0, 1)));
  endtask

  task automatic randomize_config();
    logic [LIMIT_W-1:0] lim;
    case ($urandom_range(0, 5))
      0:       lim = '0;
      1:       lim = '1;
      2:       lim = LIMIT_W'($urandom_range(0, 400));
      default: lim = LIMIT_W'($urandom());
    endcase
    write_reg(CFG_ENABLE, {(LIMIT_W-1)'($urandom()), ($urandom_range(0, 4) != 0)});
    write_reg(CFG_LIMIT, lim);
  endtask

  task automatic test_drain_before_frame();
    drain_beats(2);
  endtask

  task automatic test_extremes();
    send_beat(OP_LOAD, 16'sd32767, 1'b0);
    send_beat(OP_LOAD, -16'sd32768, 1'b0);
    send_beat(OP_LOAD, 16'sd0, 1'b0);
    send_beat(OP_LOAD, -16'sd1, 1'b0);
    send_beat(OP_LOAD, 16'sd1, 1'b1);
    drain_beats(6);
  endtask

  task automatic test_disabled();
    wait_idle();
    write_reg(CFG_ENABLE, '0);
    send_beat(OP_LOAD, -16'sd32768, 1'b0);
    send_beat(OP_LOAD, 16'sd32767, 1'b1);
    drain_beats(2);
    wait_idle();
    write_reg(CFG_ENABLE, 15'd1);
  endtask

  task automatic test_limit_extremes();
    wait_idle();
    write_reg(CFG_LIMIT, '0);
    send_beat(OP_LOAD, 16'sd100, 1'b0);
    send_beat(OP_LOAD, -16'sd7, 1'b1);
    drain_beats(2);
    send_beat(OP_LOAD, 16'sd0, 1'b1);
    drain_beats(1);
    wait_idle();
    write_reg(CFG_LIMIT, '1);
    send_beat(OP_LOAD, -16'sd32768, 1'b0);
    send_beat(OP_LOAD, 16'sd12345, 1'b1);
    drain_beats(2);
    send_beat(OP_LOAD, 16'sd32767, 1'b0);
    send_beat(OP_LOAD, -16'sd32767, 1'b1);
    drain_beats(2);
  endtask

  // limit written after close must not affect the drained frame
  task automatic test_latched_limit();
    wait_idle();
    write_reg(CFG_LIMIT, 15'd1000);
    send_beat(OP_LOAD, 16'sd20000, 1'b0);
    send_beat(OP_LOAD, -16'sd5000, 1'b1);
    wait_idle();
    write_reg(CFG_LIMIT, 15'd3);
    drain_beats(2);
  endtask

  // new frame while the old one is partly drained
  task automatic test_restart();
    load_frame(4);
    drain_beats(1);
    load_frame(3);
    drain_beats(4);
  endtask

  task automatic test_random_frames();
    int unsigned beats;
    int unsigned len;
    int unsigned n;
    int unsigned frame_no;
    beats    = 0;
    frame_no = 0;
    while (beats < RANDOM_BEATS) begin
      steady = (frame_no >= 20 && frame_no < 35);
      if ($urandom_range(0, 7) == 0) begin
        wait_idle();
        randomize_config();
      end
      len = ($urandom_range(0, 9) == 0) ? $urandom_range(13, 40) : $urandom_range(1, 12);
      load_frame(len);
      n = ($urandom_range(0, 6) == 0) ? $urandom_range(0, len - 1) : len + $urandom_range(0, 1);
      drain_beats(n);
      beats += len + n;
      if ($urandom_range(0, 9) == 0) begin
        repeat (3) send_beat(fpl_op_e'($urandom_range(0, 1)), pick_sample(),
                             1'($urandom_range(0, 1)));
        beats += 3;
      end
      frame_no++;
    end
    steady = 1'b0;
  endtask

  task automatic test_overflow();
    wait_idle();
    write_reg(CFG_ENABLE, 15'd1);
    write_reg(CFG_LIMIT, 15'd9000);
    steady = 1'b1;
    for (int unsigned k = 0; k < FRAME_DEPTH + 2; k++)
      send_beat(OP_LOAD, pick_sample(), k == FRAME_DEPTH + 1);
    steady = 1'b0;
    drain_beats(4);
  endtask

  initial begin
    rst_ni      <= 1'b0;
    in_valid_i  <= 1'b0;
    opcode_i    <= 1'b0;
    sample_in_i <= '0;
    frame_end_i <= 1'b0;
    cfg_valid_i <= 1'b0;
    cfg_index_i <= '0;
    cfg_data_i  <= '0;
    steady       = 1'b0;
    mismatch_cnt = 0;
    buf_fill     = 0;
    buf_rd       = 0;
    frame_peak   = 0;
    scale_on     = 1'b0;
    ovf_flag     = 1'b0;
    frame_done   = 1'b0;
    limit_held   = '0;
    en_cfg       = 1'b1;
    limit_cfg    = LIMIT_RST;
    repeat (4) @(posedge clk_i);
    rst_ni <= 1'b1;
    @(posedge clk_i);

    test_drain_before_frame();
    test_extremes();
    test_disabled();
    test_limit_extremes();
    test_latched_limit();
    test_restart();
    test_random_frames();
    test_overflow();

    wait_idle();
    if (mismatch_cnt == 0 && pending_results.size() == 0) begin
      $display("TEST PASSED");
    end else begin
      $display("TEST FAILED");
    end
    $finish;
  end

  always @(posedge clk_i) begin
    out_ready_i <= steady || ($urandom_range(0, 99) >= 27);
  end

  task automatic cmp_field(input string name, input int want, input int got);
    if (want != got) begin
      $display("%0t %s mismatch: expected %0d, actual %0d", $time, name, want, got);
      mismatch_cnt++;
    end
  endtask

  always @(posedge clk_i) begin : check_results
    fpl_result_t want;
    if (rst_ni && out_valid_o && out_ready_i) begin
      if (pending_results.size() == 0) begin
        $display("%0t unexpected beat: expected none, actual kind %0d sample %0d",
                 $time, result_kind_o, sample_out_o);
        mismatch_cnt++;
      end else begin
        want = pending_results.pop_front();
        cmp_field("result_kind", want.kind, result_kind_o);
        cmp_field("sample_out", want.smp, sample_out_o);
        cmp_field("last_out", want.last, last_out_o);
        cmp_field("peak_level", want.peak, peak_level_o);
        cmp_field("over_limit", want.over, over_limit_o);
        cmp_field("frame_overflow", want.ovf, frame_overflow_o);
      end
    end
  end

  always @(posedge clk_i) begin
    if (!rst_ni || (in_valid_i && in_ready_o) || (out_valid_o && out_ready_i) ||
        (cfg_valid_i && cfg_ready_o)) begin
      stall_cycles <= 0;
    end else begin
      stall_cycles <= stall_cycles + 1;
      if (stall_cycles >= STALL_LIMIT) begin
        $display("TEST FAILED");
        $finish;
      end
    end
  end

endmodule

### files.f
+incdir+design
design/fpl_pkg.sv
design/fpl_divider.sv
design/frame_peak_limiter.sv
tb/tb.sv
